// ----- rtl/assert_macros.svh -----
// Assertion helpers; both expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ----- rtl/snor_pkg.sv -----
`default_nettype none
package snor_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PROG,
    ST_ERASE
  } state_t;

  // host commands
  localparam logic [1:0] CMD_SELECT   = 2'd0;
  localparam logic [1:0] CMD_EXCHANGE = 2'd1;
  localparam logic [1:0] CMD_RELEASE  = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // opcodes
  localparam logic [7:0] OP_NONE         = 8'h00;
  localparam logic [7:0] OP_STATUS       = 8'h05;
  localparam logic [7:0] OP_WRITE_ENABLE = 8'h06;
  localparam logic [7:0] OP_READ         = 8'h03;
  localparam logic [7:0] OP_PROGRAM      = 8'h02;
  localparam logic [7:0] OP_ERASE        = 8'h20;
  localparam logic [7:0] OP_RESET_ENABLE = 8'h66;
  localparam logic [7:0] OP_RESET        = 8'h99;

  // configuration register indexes
  localparam logic CFG_PROGRAM_TICKS = 1'b0;
  localparam logic CFG_ERASE_TICKS   = 1'b1;

  localparam logic [15:0] RESET_PROGRAM_TICKS = 16'd8;
  localparam logic [15:0] RESET_ERASE_TICKS   = 16'd64;

  localparam logic [7:0] MISO_IDLE  = 8'hFF;
  localparam logic [7:0] BYTE_ERASED = 8'hFF;
  localparam logic [2:0] PHASE_OPCODE = 3'd0;
  localparam logic [2:0] ADDR_DONE    = 3'd4;

endpackage
`default_nettype wire

// ----- rtl/spi_nor_flash_device_core.sv -----
// Select, tick, status and opcode/address beats load the result register directly; a read
//   or program data beat first reads the array, then loads its result or writes the byte back.
// Release of a complete sector erase writes 0xFF over its sector (at most the whole array) first.
// Throughput: 1 beat per cycle while idle and the result register is free.
// Reset: synchronous, active high; a clearing pass then writes 0xFF to all 2^MEM_ADDR_BITS
//   array bytes, one per cycle, before the first beat is taken.
`default_nettype none
`include "assert_macros.svh"
module spi_nor_flash_device_core #(
  parameter int MEM_ADDR_BITS = 16,
  parameter int SECTOR_BYTES  = 4096,
  parameter int PAGE_BYTES    = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  mosi_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  miso_byte,
  output logic             busy_flag,
  output logic             write_enabled,
  // configuration write port
  input  wire logic        cfg_write_enable,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  import snor_pkg::*;

  localparam int MEM_SIZE    = 1 << MEM_ADDR_BITS;
  localparam int SECTOR_BITS = $clog2(SECTOR_BYTES);
  localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
  // a sector larger than the array erases the whole array
  localparam int ERASE_BITS  = (SECTOR_BITS < MEM_ADDR_BITS) ? SECTOR_BITS : MEM_ADDR_BITS;
  localparam logic [MEM_ADDR_BITS-1:0] ERASE_MASK =
    MEM_ADDR_BITS'((64'd1 << ERASE_BITS) - 64'd1);
  localparam logic [MEM_ADDR_BITS-1:0] PAGE_MASK =
    MEM_ADDR_BITS'((64'd1 << PAGE_BITS) - 64'd1);

  // control state
  state_t      state, state_next;
  logic        wel, wel_next;
  logic [15:0] busy_count, busy_count_next;
  logic        reset_armed, reset_armed_next;
  logic        frame_active, frame_active_next;
  logic [7:0]  opcode_reg, opcode_reg_next;
  logic [2:0]  byte_phase, byte_phase_next;
  logic [23:0] address_reg, address_reg_next;
  logic        program_seen, program_seen_next;
  logic [15:0] program_ticks, program_ticks_next;
  logic [15:0] erase_ticks, erase_ticks_next;
  logic [MEM_ADDR_BITS-1:0] sweep_cnt, sweep_cnt_next;
  logic        out_valid_next;

  // payload
  logic [7:0]  pend_byte, pend_byte_next;
  logic [7:0]  miso_byte_next;
  logic        busy_flag_next;
  logic        write_enabled_next;

  // array port
  logic                     mem_we;
  logic [MEM_ADDR_BITS-1:0] mem_waddr;
  logic [7:0]               mem_wdata;
  logic                     mem_re;
  logic [7:0]               mem_rdata;

  logic                     accept;
  logic                     out_free;
  logic                     frame_xchg;
  logic                     frame_rel;
  logic                     data_phase;
  logic                     do_read;
  logic                     do_prog;
  logic                     do_erase;
  logic                     sweep_last;
  logic [MEM_ADDR_BITS-1:0] idx;
  logic [MEM_ADDR_BITS-1:0] idx_inc;
  logic [7:0]               opcode_decoded;
  logic                     load;

  // assertion terms
  logic                     sweep_cycle;
  logic                     erased_wr;
  logic                     mem_pending;
  logic                     prog_wr;
  logic                     prog_ok;

  snor_ram #(
    .WIDTH(8),
    .DEPTH(MEM_SIZE)
  ) u_array (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(idx),
    .rdata(mem_rdata)
  );

  // Take a new beat only in idle, and only when the result register is free or
  // drains this cycle, so every accepted beat has a slot for its result.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign idx        = address_reg[MEM_ADDR_BITS-1:0];
  assign idx_inc    = idx + MEM_ADDR_BITS'(1);
  assign data_phase = (byte_phase == ADDR_DONE);
  assign frame_xchg = accept && (command == CMD_EXCHANGE) && frame_active;
  assign frame_rel  = accept && (command == CMD_RELEASE) && frame_active;
  assign do_read    = frame_xchg && data_phase && (opcode_reg == OP_READ);
  assign do_prog    = frame_xchg && data_phase && (opcode_reg == OP_PROGRAM);
  assign do_erase   = frame_rel && data_phase && (opcode_reg == OP_ERASE);

  // The clearing pass walks the whole array, an erase walks one sector.
  assign sweep_last = (state == ST_CLEAR) ? (&sweep_cnt)
                                          : ((sweep_cnt & ERASE_MASK) == ERASE_MASK);

  // Opcode as latched: demote to a no-op while busy (status excepted) and
  // demote program/erase when the write enable latch is clear.
  always_comb begin
    opcode_decoded = mosi_byte;
    if ((busy_count != 16'd0) && (mosi_byte != OP_STATUS)) begin
      opcode_decoded = OP_NONE;
    end
    if (((opcode_decoded == OP_PROGRAM) || (opcode_decoded == OP_ERASE)) && !wel) begin
      opcode_decoded = OP_NONE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (do_read) begin
          state_next = ST_READ;
        end else if (do_prog) begin
          state_next = ST_PROG;
        end else if (do_erase) begin
          state_next = ST_ERASE;
        end
      end
      ST_READ, ST_PROG: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_ERASE: begin
        if (sweep_last && out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath, array port and result
  always_comb begin
    wel_next           = wel;
    busy_count_next    = busy_count;
    reset_armed_next   = reset_armed;
    frame_active_next  = frame_active;
    opcode_reg_next    = opcode_reg;
    byte_phase_next    = byte_phase;
    address_reg_next   = address_reg;
    program_seen_next  = program_seen;
    program_ticks_next = program_ticks;
    erase_ticks_next   = erase_ticks;
    sweep_cnt_next     = sweep_cnt;
    pend_byte_next     = pend_byte;
    miso_byte_next     = miso_byte;
    load               = 1'b0;

    mem_we    = 1'b0;
    mem_waddr = (idx & ~ERASE_MASK) | (sweep_cnt & ERASE_MASK);
    mem_wdata = BYTE_ERASED;
    mem_re    = 1'b0;

    if (cfg_write_enable) begin
      case (cfg_index)
        CFG_PROGRAM_TICKS: program_ticks_next = cfg_data;
        CFG_ERASE_TICKS:   erase_ticks_next   = cfg_data;
        default: ;
      endcase
    end

    case (state)
      ST_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = sweep_cnt;
        sweep_cnt_next = sweep_cnt + MEM_ADDR_BITS'(1);
      end

      ST_IDLE: begin
        if (accept) begin
          miso_byte_next = MISO_IDLE;
          load           = 1'b1;
          case (command)
            CMD_SELECT: begin
              // open a fresh frame; an open one is dropped without its release actions
              frame_active_next = 1'b1;
              opcode_reg_next   = OP_NONE;
              byte_phase_next   = PHASE_OPCODE;
              address_reg_next  = 24'd0;
              program_seen_next = 1'b0;
            end
            CMD_EXCHANGE: begin
              if (frame_active) begin
                if (byte_phase == PHASE_OPCODE) begin
                  opcode_reg_next = opcode_decoded;
                  byte_phase_next = 3'd1;
                end else if (opcode_reg == OP_STATUS) begin
                  miso_byte_next = {6'd0, wel, busy_count != 16'd0};
                end else if ((opcode_reg == OP_READ) || (opcode_reg == OP_PROGRAM) ||
                             (opcode_reg == OP_ERASE)) begin
                  if (!data_phase) begin
                    // shift in the address, MSB first
                    address_reg_next = {address_reg[15:0], mosi_byte};
                    byte_phase_next  = byte_phase + 3'd1;
                  end else if (opcode_reg == OP_READ) begin
                    mem_re = 1'b1;
                    load   = 1'b0;
                  end else if (opcode_reg == OP_PROGRAM) begin
                    mem_re         = 1'b1;
                    pend_byte_next = mosi_byte;
                    load           = 1'b0;
                  end
                end
              end
            end
            CMD_RELEASE: begin
              if (frame_active) begin
                reset_armed_next  = 1'b0;
                frame_active_next = 1'b0;
                case (opcode_reg)
                  OP_WRITE_ENABLE: wel_next = 1'b1;
                  OP_RESET_ENABLE: reset_armed_next = 1'b1;
                  OP_RESET: begin
                    if (reset_armed) begin
                      wel_next        = 1'b0;
                      busy_count_next = 16'd0;
                    end
                  end
                  OP_PROGRAM: begin
                    if (data_phase && program_seen) begin
                      wel_next        = 1'b0;
                      busy_count_next = program_ticks;
                    end
                  end
                  OP_ERASE: begin
                    if (data_phase) begin
                      // status changes now; the result waits for the sweep
                      wel_next        = 1'b0;
                      busy_count_next = erase_ticks;
                      sweep_cnt_next  = '0;
                      load            = 1'b0;
                    end
                  end
                  default: ;
                endcase
              end
            end
            CMD_TICK: begin
              if (busy_count != 16'd0) busy_count_next = busy_count - 16'd1;
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        if (out_free) begin
          miso_byte_next   = mem_rdata;
          address_reg_next = 24'(idx_inc);
          load             = 1'b1;
        end
      end

      ST_PROG: begin
        // write back once the result slot is free; the next access to the
        // array cannot issue before this write lands
        if (out_free) begin
          mem_we            = 1'b1;
          mem_waddr         = idx;
          mem_wdata         = mem_rdata & pend_byte;
          address_reg_next  = 24'((idx & ~PAGE_MASK) | (idx_inc & PAGE_MASK));
          program_seen_next = 1'b1;
          miso_byte_next    = MISO_IDLE;
          load              = 1'b1;
        end
      end

      ST_ERASE: begin
        mem_we = 1'b1;
        if (!sweep_last) begin
          sweep_cnt_next = sweep_cnt + MEM_ADDR_BITS'(1);
        end else if (out_free) begin
          miso_byte_next = MISO_IDLE;
          load           = 1'b1;
        end
      end

      default: ;
    endcase

    busy_flag_next     = busy_flag;
    write_enabled_next = write_enabled;
    if (load) begin
      busy_flag_next     = (busy_count_next != 16'd0);
      write_enabled_next = wel_next;
    end else begin
      miso_byte_next = miso_byte;
    end
    out_valid_next = load || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      wel           <= 1'b0;
      busy_count    <= 16'd0;
      reset_armed   <= 1'b0;
      frame_active  <= 1'b0;
      opcode_reg    <= OP_NONE;
      byte_phase    <= PHASE_OPCODE;
      address_reg   <= 24'd0;
      program_seen  <= 1'b0;
      program_ticks <= RESET_PROGRAM_TICKS;
      erase_ticks   <= RESET_ERASE_TICKS;
      sweep_cnt     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      wel           <= wel_next;
      busy_count    <= busy_count_next;
      reset_armed   <= reset_armed_next;
      frame_active  <= frame_active_next;
      opcode_reg    <= opcode_reg_next;
      byte_phase    <= byte_phase_next;
      address_reg   <= address_reg_next;
      program_seen  <= program_seen_next;
      program_ticks <= program_ticks_next;
      erase_ticks   <= erase_ticks_next;
      sweep_cnt     <= sweep_cnt_next;
      out_valid     <= out_valid_next;
    end
  end

  // payload registers: loaded only when the result slot is free
  always_ff @(posedge clk) begin
    pend_byte     <= pend_byte_next;
    miso_byte     <= miso_byte_next;
    busy_flag     <= busy_flag_next;
    write_enabled <= write_enabled_next;
  end

  assign sweep_cycle = (state == ST_CLEAR) || (state == ST_ERASE);
  assign erased_wr   = mem_we && (mem_wdata == BYTE_ERASED);
  assign mem_pending = (state == ST_READ) || (state == ST_PROG);
  assign prog_wr     = (state == ST_PROG) && mem_we;
  assign prog_ok     = (opcode_reg == OP_PROGRAM) && data_phase && frame_active;

  // every sweep cycle writes an erased byte
  `ASSERT_IMPLIES(a_sweep_writes_erased, clk, rst, sweep_cycle, erased_wr, "bad sweep write")
  // an array read is always followed by its consuming state
  `ASSERT_NEXT(a_read_consumed, clk, rst, mem_re, mem_pending, "read with no consumer")
  // a program write back only happens inside a program data phase
  `ASSERT_IMPLIES(a_prog_write_in_frame, clk, rst, prog_wr, prog_ok, "stray program write")

endmodule
`default_nettype wire

// ----- rtl/snor_ram.sv -----
`default_nettype none
module snor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_spi_nor_flash_device_core.sv -----
`default_nettype none
module tb_spi_nor_flash_device_core;
  timeunit 1ns;
  timeprecision 1ps;
  import snor_pkg::*;

  // Geometry of the default build; the predictor mirrors it.
  localparam int MEM_BITS      = 16;
  localparam int SECTOR_BITS   = 12;
  localparam int PAGE_BITS     = 8;
  // A sector erase keeps the array port busy while it sweeps one sector.
  localparam int SETTLE_CYCLES = 4200;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
  } host_beat_t;

  typedef struct {
    logic [7:0] miso;
    logic       busy;
    logic       wel;
  } flash_reply_t;

  logic        clk;
  logic        rst              = 1'b1;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [1:0]  command          = CMD_TICK;
  logic [7:0]  mosi_byte        = 8'h00;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [7:0]  miso_byte;
  logic        busy_flag;
  logic        write_enabled;
  logic        cfg_write_enable = 1'b0;
  logic        cfg_index        = CFG_PROGRAM_TICKS;
  logic [15:0] cfg_data         = 16'd0;

  spi_nor_flash_device_core #(
    .MEM_ADDR_BITS(MEM_BITS),
    .SECTOR_BYTES (1 << SECTOR_BITS),
    .PAGE_BYTES   (1 << PAGE_BITS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .mosi_byte       (mosi_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .miso_byte       (miso_byte),
    .busy_flag       (busy_flag),
    .write_enabled   (write_enabled),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Beats waiting to be driven, and replies the device still owes us.
  host_beat_t   beat_queue[$];
  flash_reply_t replies_due[$];

  // When low, neither side inserts gaps or stalls.
  bit idle_on = 1'b1;

  int error_count     = 0;
  int beats_taken     = 0;
  int replies_checked = 0;
  int queued_beats    = 0;
  int programs_done   = 0;
  int erases_done     = 0;
  int resets_done     = 0;

  // Shadow copy of the device: array, status latches and frame decoder.
  logic [7:0]  flash_img [0:(1 << MEM_BITS) - 1];
  logic        wel;
  logic        reset_arm;
  logic        in_frame;
  logic        prog_seen;
  logic [15:0] busy_left;
  logic [15:0] prog_ticks;
  logic [15:0] erase_ticks;
  logic [7:0]  op_held;
  logic [2:0]  frame_step;
  logic [23:0] addr_held;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the device hangs or drops a reply.
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic log_error(input string msg);
    error_count++;
    if (error_count <= 50) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Handle one exchanged byte inside an open frame; return what the device drives.
  function automatic logic [7:0] predict_miso(input logic [7:0] b);
    logic [7:0]          op;
    logic [7:0]          rd;
    logic [MEM_BITS-1:0] idx;
    rd  = MISO_IDLE;
    idx = addr_held[MEM_BITS-1:0];
    if (frame_step == PHASE_OPCODE) begin
      // While busy only status is decoded; program and erase need the latch.
      op = b;
      if (busy_left != 16'd0 && op != OP_STATUS) op = OP_NONE;
      if ((op == OP_PROGRAM || op == OP_ERASE) && !wel) op = OP_NONE;
      op_held    = op;
      frame_step = frame_step + 3'd1;
    end else if (op_held == OP_STATUS) begin
      rd = {6'd0, wel, busy_left != 16'd0};
    end else if (op_held == OP_READ || op_held == OP_PROGRAM || op_held == OP_ERASE) begin
      if (frame_step != ADDR_DONE) begin
        // Address arrives MSB first; bits above the array are kept but unused.
        addr_held  = {addr_held[15:0], b};
        frame_step = frame_step + 3'd1;
      end else if (op_held == OP_READ) begin
        rd        = flash_img[idx];
        idx       = idx + 1'b1;
        addr_held = '0;
        addr_held[MEM_BITS-1:0] = idx;
      end else if (op_held == OP_PROGRAM) begin
        // Program can only clear bits; the column wraps inside the page.
        flash_img[idx] = flash_img[idx] & b;
        idx[PAGE_BITS-1:0] = idx[PAGE_BITS-1:0] + 1'b1;
        addr_held = '0;
        addr_held[MEM_BITS-1:0] = idx;
        prog_seen = 1'b1;
      end
    end
    return rd;
  endfunction

  // Apply the release actions of the open frame.
  function automatic void finish_frame();
    logic                arm;
    logic [MEM_BITS-1:0] base;
    arm  = 1'b0;
    base = '0;
    base[MEM_BITS-1:SECTOR_BITS] = addr_held[MEM_BITS-1:SECTOR_BITS];
    case (op_held)
      OP_WRITE_ENABLE: wel = 1'b1;
      OP_RESET_ENABLE: arm = 1'b1;
      OP_RESET: begin
        if (reset_arm) begin
          wel       = 1'b0;
          busy_left = 16'd0;
          resets_done++;
        end
      end
      OP_PROGRAM: begin
        if (frame_step == ADDR_DONE && prog_seen) begin
          wel       = 1'b0;
          busy_left = prog_ticks;
          programs_done++;
        end
      end
      OP_ERASE: begin
        if (frame_step == ADDR_DONE) begin
          for (int i = 0; i < (1 << SECTOR_BITS); i++)
            flash_img[base | MEM_BITS'(i)] = BYTE_ERASED;
          wel       = 1'b0;
          busy_left = erase_ticks;
          erases_done++;
        end
      end
      default: ;
    endcase
    // Any other completed frame disarms a pending reset.
    reset_arm = arm;
    in_frame  = 1'b0;
  endfunction

  // Advance the shadow device by one accepted beat and queue the reply it owes.
  function automatic void predict_flash_reply(input logic [1:0] cmd, input logic [7:0] b);
    flash_reply_t r;
    r.miso = MISO_IDLE;
    case (cmd)
      CMD_SELECT: begin
        // A select inside a frame drops it without release actions.
        in_frame   = 1'b1;
        op_held    = OP_NONE;
        frame_step = PHASE_OPCODE;
        addr_held  = '0;
        prog_seen  = 1'b0;
      end
      CMD_EXCHANGE: if (in_frame) r.miso = predict_miso(b);
      CMD_RELEASE:  if (in_frame) finish_frame();
      default:      if (busy_left != 16'd0) busy_left = busy_left - 16'd1;
    endcase
    r.busy = busy_left != 16'd0;
    r.wel  = wel;
    replies_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Host driver: present queued beats, with random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_host
    host_beat_t nxt;
    int         gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      // Predict on the beat the device takes at this edge.
      if (in_valid && !in_stall) begin
        predict_flash_reply(command, mosi_byte);
        beats_taken++;
      end
      // Hold a stalled beat; otherwise idle or advance to the next one.
      if (!in_valid || !in_stall) begin
        if (idle_on && gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beat_queue.size() != 0) begin
          nxt = beat_queue.pop_front();
          in_valid  <= 1'b1;
          command   <= nxt.cmd;
          mosi_byte <= nxt.data;
          if (idle_on && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reply monitor: check each accepted reply, stall in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_replies
    flash_reply_t want;
    int           stall_left;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          log_error($sformatf("unexpected reply, miso %02h", miso_byte));
        end else begin
          want = replies_due.pop_front();
          replies_checked++;
          if (miso_byte !== want.miso)
            log_error($sformatf("reply %0d: miso %02h, want %02h",
                                replies_checked, miso_byte, want.miso));
          if (busy_flag !== want.busy)
            log_error($sformatf("reply %0d: busy %b, want %b",
                                replies_checked, busy_flag, want.busy));
          if (write_enabled !== want.wel)
            log_error($sformatf("reply %0d: write enable %b, want %b",
                                replies_checked, write_enabled, want.wel));
        end
      end
      if (idle_on && stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = 0;
        if (idle_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put(input logic [1:0] cmd, input logic [7:0] b);
    host_beat_t t;
    t.cmd  = cmd;
    t.data = b;
    beat_queue.push_back(t);
    queued_beats++;
  endtask

  // Loose beat, ignored unless a frame was left open; not counted toward the stimulus size.
  task automatic put_stray(input logic [1:0] cmd);
    host_beat_t t;
    t.cmd  = cmd;
    t.data = 8'($urandom);
    beat_queue.push_back(t);
  endtask

  task automatic put_ticks(input int n);
    for (int i = 0; i < n; i++) put(CMD_TICK, 8'($urandom));
  endtask

  // Full frame: select, opcode, addr_len address bytes, data_len data bytes, release.
  task automatic put_frame(input logic [7:0] op, input int addr_len, input logic [23:0] a,
                           input int data_len);
    put(CMD_SELECT, 8'($urandom));
    put(CMD_EXCHANGE, op);
    for (int i = 0; i < addr_len; i++) put(CMD_EXCHANGE, a[23 - 8 * i -: 8]);
    // OR of two draws keeps most bits set so programmed bytes decay slowly.
    for (int i = 0; i < data_len; i++) put(CMD_EXCHANGE, 8'($urandom | $urandom));
    put(CMD_RELEASE, 8'($urandom));
  endtask

  // Mostly a few pages in the first two sectors, often near a page end.
  function automatic logic [23:0] pick_addr();
    logic [23:0] a;
    a = 24'($urandom);
    if ($urandom_range(0, 7) != 0) begin
      a[15:12] = 4'($urandom_range(0, 1));
      a[11:8]  = 4'($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) a[7:0] = 8'($urandom_range(248, 255));
    end
    return a;
  endfunction

  // Often let a busy countdown run out so later commands get through.
  task automatic run_out_busy(input logic [15:0] ticks);
    if (ticks <= 16'd40 && $urandom_range(0, 2) != 0) put_ticks(ticks + $urandom_range(0, 2));
  endtask

  task automatic put_random_sequence();
    int pick;
    int alen;
    pick = $urandom_range(0, 99);
    alen = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : 3;
    if (pick < 12) begin
      put_frame(OP_STATUS, 0, '0, $urandom_range(1, 4));
    end else if (pick < 22) begin
      put_frame(OP_WRITE_ENABLE, 0, '0, $urandom_range(0, 1));
    end else if (pick < 44) begin
      if ($urandom_range(0, 3) != 0) put_frame(OP_WRITE_ENABLE, 0, '0, 0);
      put_frame(OP_PROGRAM, alen, pick_addr(),
                ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10));
      run_out_busy(prog_ticks);
    end else if (pick < 64) begin
      put_frame(OP_READ, alen, pick_addr(), $urandom_range(0, 10));
    end else if (pick < 68) begin
      if ($urandom_range(0, 3) != 0) put_frame(OP_WRITE_ENABLE, 0, '0, 0);
      put_frame(OP_ERASE, alen, pick_addr(), $urandom_range(0, 2));
      run_out_busy(erase_ticks);
    end else if (pick < 78) begin
      put_ticks($urandom_range(1, 6));
    end else if (pick < 84) begin
      // Reset enable, then usually the reset itself, sometimes something else.
      put_frame(OP_RESET_ENABLE, 0, '0, $urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0) put_frame(OP_RESET, 0, '0, 0);
      else put_frame(OP_STATUS, 0, '0, 1);
    end else if (pick < 87) begin
      put_frame(OP_RESET, 0, '0, 0);
    end else if (pick < 92) begin
      put_frame(8'($urandom), $urandom_range(0, 3), 24'($urandom), $urandom_range(0, 3));
    end else if (pick < 96) begin
      // Open a frame and leave it; the next select abandons it.
      put(CMD_SELECT, 8'($urandom));
      put(CMD_EXCHANGE, ($urandom_range(0, 1) == 0) ? OP_READ : 8'($urandom));
      for (int i = $urandom_range(0, 4); i > 0; i--) put(CMD_EXCHANGE, 8'($urandom));
    end else begin
      put_stray(($urandom_range(0, 1) == 0) ? CMD_EXCHANGE : CMD_RELEASE);
    end
  endtask

  task automatic put_random_block(input int n);
    int goal;
    goal = queued_beats + n;
    while (queued_beats < goal) put_random_sequence();
  endtask

  // Pause the sender until every owed reply has arrived.
  task automatic drain_replies();
    while (beat_queue.size() != 0 || in_valid || replies_due.size() != 0) @(negedge clk);
  endtask

  // Drain, then let any erase still writing the array finish.
  task automatic quiesce();
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ticks(input logic [15:0] prog, input logic [15:0] erase);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= CFG_PROGRAM_TICKS;
    cfg_data         <= prog;
    @(posedge clk);
    cfg_index        <= CFG_ERASE_TICKS;
    cfg_data         <= erase;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    prog_ticks  = prog;
    erase_ticks = erase;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Shadow device comes out of reset erased and idle.
    for (int i = 0; i < (1 << MEM_BITS); i++) flash_img[MEM_BITS'(i)] = BYTE_ERASED;
    wel         = 1'b0;
    reset_arm   = 1'b0;
    in_frame    = 1'b0;
    prog_seen   = 1'b0;
    busy_left   = 16'd0;
    op_held     = OP_NONE;
    frame_step  = PHASE_OPCODE;
    addr_held   = '0;
    prog_ticks  = RESET_PROGRAM_TICKS;
    erase_ticks = RESET_ERASE_TICKS;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Short busy times so the directed beats see the countdown end.
    set_ticks(16'd2, 16'd3);

    // Exchange and release with no frame open.
    put_stray(CMD_EXCHANGE);
    put_stray(CMD_RELEASE);
    // Status, then set the write enable latch.
    put_frame(OP_STATUS, 0, '0, 1);
    put_frame(OP_WRITE_ENABLE, 0, '0, 0);
    // Program three bytes from the page's second-to-last column; upper address
    // bits are junk and the third byte wraps to the page start.
    put(CMD_SELECT, 8'h00);
    put(CMD_EXCHANGE, OP_PROGRAM);
    put(CMD_EXCHANGE, 8'hFF);
    put(CMD_EXCHANGE, 8'h01);
    put(CMD_EXCHANGE, 8'hFE);
    put(CMD_EXCHANGE, 8'h00);
    put(CMD_EXCHANGE, 8'h5A);
    put(CMD_EXCHANGE, 8'hFF);
    put(CMD_RELEASE, 8'hFF);
    put_ticks(2);
    // Read across the page boundary: reads do not wrap inside a page.
    put(CMD_SELECT, 8'h00);
    put(CMD_EXCHANGE, OP_READ);
    put(CMD_EXCHANGE, 8'h80);
    put(CMD_EXCHANGE, 8'h01);
    put(CMD_EXCHANGE, 8'hFF);
    put(CMD_EXCHANGE, 8'hC3);
    put(CMD_EXCHANGE, 8'h3C);
    put(CMD_RELEASE, 8'h00);
    quiesce();

    // Main random traffic with short busy times; pause once midway.
    set_ticks(16'($urandom_range(1, 16)), 16'($urandom_range(1, 40)));
    put_random_block(550);
    drain_replies();
    put_random_block(500);
    quiesce();

    // Zero busy ticks: busy must never show.
    set_ticks(16'd0, 16'd0);
    put_random_block(450);
    quiesce();

    // Last stretch runs with no gaps and no stalls.
    idle_on = 1'b0;
    set_ticks(16'($urandom_range(1, 16)), 16'($urandom_range(1, 40)));
    put_random_block(400);
    quiesce();

    // Largest busy times: an erase leaves the device busy for the rest of the
    // run, so everything but status, including reset, must be refused.
    set_ticks(16'hFFFF, 16'hFFFF);
    put_frame(OP_WRITE_ENABLE, 0, '0, 0);
    put_frame(OP_ERASE, 3, 24'hA5_1000, 1);
    put_frame(OP_STATUS, 0, '0, 2);
    put_ticks(4);
    put_frame(OP_WRITE_ENABLE, 0, '0, 0);
    put_frame(OP_RESET_ENABLE, 0, '0, 0);
    put_frame(OP_RESET, 0, '0, 0);
    put_frame(OP_READ, 3, 24'h00_01FE, 2);
    put_frame(OP_STATUS, 0, '0, 1);
    quiesce();

    $display("Ran %0d host beats and checked %0d replies over five busy-time settings.",
             beats_taken, replies_checked);
    $display("Device completed %0d programs, %0d sector erases and %0d soft resets.",
             programs_done, erases_done, resets_done);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
